// ===== hw/rtl/itc_pkg.sv =====
// Shared types, constants and register codes of the impact-triggered capture block.
`timescale 1ns / 1ps

package itc_pkg;

    localparam int CAPTURE_DEPTH = 15;
    // fill index counts 0 .. CAPTURE_DEPTH
    localparam int IDX_W    = $clog2(CAPTURE_DEPTH + 1);
    localparam int RAM_AW   = $clog2(CAPTURE_DEPTH);
    localparam int REC_W    = 96;
    localparam int ADDR_W   = 3;

    localparam logic [1:0] KIND_NOTICE    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE    = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_INTERVAL  = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1500;
    localparam logic [15:0] INTERVAL_RESET  = 16'd500;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [13:0] pressure_tenths;
        logic signed [11:0] temperature_tenths;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  record_kind;
        logic        [3:0]  record_number;
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic        [13:0] out_pressure;
        logic signed [11:0] out_temperature;
        logic               last_record;
    } t_out_item;

    typedef struct packed {
        logic done;
        logic hit;
    } t_mac_status;

endpackage

// ===== hw/rtl/itc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module itc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/itc_mac.sv =====
// Shared squaring multiplier and accumulator for the impact magnitude test.
`timescale 1ns / 1ps

module itc_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  itc_pkg::t_in_item     i_item,
    input  logic [15:0]           i_threshold,
    output itc_pkg::t_mac_status  o_status
);

    localparam logic [2:0] STEP_X   = 3'd0;
    localparam logic [2:0] STEP_Y   = 3'd1;
    localparam logic [2:0] STEP_Z   = 3'd2;
    localparam logic [2:0] STEP_THR = 3'd3;
    localparam logic [2:0] STEP_CMP = 3'd4;

    logic               r_busy;
    logic [2:0]         r_step;
    logic [31:0]        r_prod;
    logic [31:0]        r_acc;
    logic               r_done;
    logic               r_hit;
    logic signed [16:0] op;
    logic signed [33:0] prod_full;

    // one operand per step: three accel axes, then the threshold
    always_comb begin
        case (r_step)
            STEP_X:   op = {i_item.accel_x[15], i_item.accel_x};
            STEP_Y:   op = {i_item.accel_y[15], i_item.accel_y};
            STEP_Z:   op = {i_item.accel_z[15], i_item.accel_z};
            STEP_THR: op = {1'b0, i_threshold};
            default:  op = '0;
        endcase
    end

    assign prod_full = op * op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_X;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_X;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step <= STEP_THR) begin
                    r_prod <= prod_full[31:0];
                end
                // the product register holds the product of the previous step
                if (r_step >= STEP_Y && r_step <= STEP_THR) begin
                    r_acc <= r_acc + r_prod;
                end
                if (r_step == STEP_CMP) begin
                    r_hit  <= r_acc > r_prod;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.hit  = r_hit;

endmodule

// ===== hw/rtl/impact_triggered_capture_unit.sv =====
// Top level: sequencer, capture buffer, registers and result register.
// A notice or heartbeat passes through the shared squaring multiplier, the decision and a
// load into the result register; a flushed record also waits for its buffer RAM read.
// Samples are accepted only while the sequencer is idle; a flush reads and loads each
// buffered record in turn (RAM read, then result load). Output stalls hold the sequencer.
// Reset: synchronous active low, back to defaults; buffer contents undefined until written.
`timescale 1ns / 1ps

module impact_triggered_capture_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  itc_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output itc_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [itc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_NOTICE,
        S_FLUSH_RD,
        S_FLUSH_OUT,
        S_HEART
    } t_state;

    t_state                     r_state, n_state;
    itc_pkg::t_in_item          r_item;
    logic                       r_capturing, n_capturing;
    logic [itc_pkg::IDX_W-1:0]  r_fill, n_fill;
    logic [15:0]                r_count, n_count;
    logic                       r_do_hb, n_do_hb;
    logic [itc_pkg::IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic                       r_out_valid, n_out_valid;
    itc_pkg::t_out_item         r_out, n_out;
    logic [15:0]                r_thr;
    logic [15:0]                r_interval;

    logic                       in_accept;
    logic                       out_free;
    logic                       cfg_write;
    itc_pkg::t_mac_status       mac_st;
    logic                       ram_we;
    logic [itc_pkg::RAM_AW-1:0] ram_waddr;
    logic [itc_pkg::REC_W-1:0]  ram_wdata;
    logic [itc_pkg::REC_W-1:0]  ram_rdata;
    logic                       trig;
    logic                       cap_new;
    logic                       flush;
    logic [15:0]                cnt_inc;
    logic [15:0]                cnt_post;
    logic                       hb;
    itc_pkg::t_out_item         blank;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr[itc_pkg::ADDR_W-1:2])
            itc_pkg::REG_THRESHOLD: prdata = {16'h0000, r_thr};
            itc_pkg::REG_INTERVAL:  prdata = {16'h0000, r_interval};
            default:                prdata = '0;
        endcase
    end

    itc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_item     (r_item),
        .i_threshold(r_thr),
        .o_status   (mac_st)
    );

    itc_ram #(
        .WIDTH(itc_pkg::REC_W),
        .DEPTH(itc_pkg::CAPTURE_DEPTH)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_rd_idx[itc_pkg::RAM_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // decision made once the magnitude test is done
    assign trig    = !r_capturing && mac_st.hit;
    assign cap_new = r_capturing || trig;
    assign flush   = r_capturing && (r_fill == itc_pkg::IDX_W'(itc_pkg::CAPTURE_DEPTH));
    assign cnt_inc = (r_count < itc_pkg::COUNT_MAX) ? r_count + 16'd1 : r_count;
    assign cnt_post = flush ? 16'd0 : cnt_inc;
    assign hb      = cnt_post > r_interval;

    assign ram_we    = (r_state == S_CALC) && mac_st.done && !flush;
    assign ram_waddr = cap_new ? r_fill[itc_pkg::RAM_AW-1:0] : '0;
    assign ram_wdata = {r_item.gyro_z, r_item.gyro_y, r_item.gyro_x,
                        r_item.accel_z, r_item.accel_y, r_item.accel_x};

    always_comb begin
        blank                 = '0;
        blank.out_pressure    = r_item.pressure_tenths;
        blank.out_temperature = r_item.temperature_tenths;
    end

    always_comb begin
        n_state     = r_state;
        n_capturing = r_capturing;
        n_fill      = r_fill;
        n_count     = r_count;
        n_do_hb     = r_do_hb;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (mac_st.done) begin
                    n_do_hb  = hb;
                    n_count  = hb ? 16'd0 : cnt_post;
                    n_rd_idx = '0;
                    if (!cap_new) begin
                        n_fill = itc_pkg::IDX_W'(1);
                    end else if (!flush) begin
                        n_fill = r_fill + itc_pkg::IDX_W'(1);
                    end else begin
                        n_fill      = '0;
                        n_capturing = 1'b0;
                    end
                    if (trig) begin
                        n_capturing = 1'b1;
                        n_state     = S_NOTICE;
                    end else if (flush) begin
                        n_state = S_FLUSH_RD;
                    end else if (hb) begin
                        n_state = S_HEART;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NOTICE: begin
                if (out_free) begin
                    n_out             = blank;
                    n_out.record_kind = itc_pkg::KIND_NOTICE;
                    n_out.last_record = !r_do_hb;
                    n_out_valid       = 1'b1;
                    n_state           = r_do_hb ? S_HEART : S_IDLE;
                end
            end
            S_FLUSH_RD: begin
                // read data for r_rd_idx arrives next cycle
                n_state = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (out_free) begin
                    n_out               = blank;
                    n_out.record_kind   = itc_pkg::KIND_SAMPLE;
                    n_out.record_number = 4'(r_rd_idx);
                    n_out.out_accel_x   = $signed(ram_rdata[15:0]);
                    n_out.out_accel_y   = $signed(ram_rdata[31:16]);
                    n_out.out_accel_z   = $signed(ram_rdata[47:32]);
                    n_out.out_gyro_x    = $signed(ram_rdata[63:48]);
                    n_out.out_gyro_y    = $signed(ram_rdata[79:64]);
                    n_out.out_gyro_z    = $signed(ram_rdata[95:80]);
                    n_out_valid         = 1'b1;
                    if (r_rd_idx == itc_pkg::IDX_W'(itc_pkg::CAPTURE_DEPTH - 1)) begin
                        n_out.last_record = !r_do_hb;
                        n_state           = r_do_hb ? S_HEART : S_IDLE;
                    end else begin
                        n_out.last_record = 1'b0;
                        n_rd_idx          = r_rd_idx + itc_pkg::IDX_W'(1);
                        n_state           = S_FLUSH_RD;
                    end
                end
            end
            S_HEART: begin
                if (out_free) begin
                    n_out             = blank;
                    n_out.record_kind = itc_pkg::KIND_HEARTBEAT;
                    n_out.last_record = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capturing <= 1'b0;
            r_fill      <= '0;
            r_count     <= '0;
            r_do_hb     <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= itc_pkg::THRESHOLD_RESET;
            r_interval  <= itc_pkg::INTERVAL_RESET;
        end else begin
            r_state     <= n_state;
            r_capturing <= n_capturing;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_do_hb     <= n_do_hb;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            if (cfg_write) begin
                case (paddr[itc_pkg::ADDR_W-1:2])
                    itc_pkg::REG_THRESHOLD: r_thr      <= pwdata[15:0];
                    itc_pkg::REG_INTERVAL:  r_interval <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
        // payload registers
        r_out <= n_out;
        if (in_accept) begin
            r_item <= i_in_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input request accepted while sequencer stays idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= itc_pkg::IDX_W'(itc_pkg::CAPTURE_DEPTH)
        && (r_capturing || r_fill <= itc_pkg::IDX_W'(1)))
        else $error("fill index out of range for capture state");

    a_mac_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_st.done |-> r_state == S_CALC)
        else $error("magnitude result arrived outside the decision state");

    a_notice_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.record_kind != itc_pkg::KIND_SAMPLE)
        |-> (o_out_data.record_number == 4'd0 && o_out_data.out_accel_x == 16'sd0
             && o_out_data.out_gyro_z == 16'sd0))
        else $error("non-sample request carries sample data");

endmodule

// ===== sim/tb_impact_triggered_capture_unit.sv =====
// Self-checking testbench for the impact-triggered capture unit: directed table, random phases.
`timescale 1ns / 1ps

module tb_impact_triggered_capture_unit;

    import itc_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_SAMPLES = 36;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [0:0]  reg_id;
        logic [15:0] value;
        t_in_item    item;
        bit          typed;
        int          typed_n;
        logic [1:0]  typed_kind;
    } t_stim_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    t_in_item            in_data = '0;
    logic                out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    wire                 in_stall;
    wire                 out_valid;
    t_out_item           out_data;
    wire  [31:0]         prdata;
    wire                 pready;

    // predictor state
    logic [15:0] thr_q = THRESHOLD_RESET;
    logic [15:0] interval_q = INTERVAL_RESET;
    logic [15:0] sample_cnt = '0;
    logic        capturing_q = 1'b0;
    int          fill_idx = 0;
    t_in_item    held[CAPTURE_DEPTH];

    t_out_item   step_recs[$];
    t_out_item   pending_recs[$];
    t_stim_row   plan[$];

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int error_count = 0;
    int samples_sent = 0;
    int reg_writes = 0;
    int notice_seen = 0;
    int record_seen = 0;
    int beat_seen = 0;

    impact_triggered_capture_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic t_out_item make_record(input logic [1:0] kind, input logic [3:0] num,
                                              input t_in_item src, input t_in_item cur);
        t_out_item r;
        r = '0;
        r.record_kind   = kind;
        r.record_number = num;
        if (kind == KIND_SAMPLE) begin
            r.out_accel_x = src.accel_x;
            r.out_accel_y = src.accel_y;
            r.out_accel_z = src.accel_z;
            r.out_gyro_x  = src.gyro_x;
            r.out_gyro_y  = src.gyro_y;
            r.out_gyro_z  = src.gyro_z;
        end
        r.out_pressure    = cur.pressure_tenths;
        r.out_temperature = cur.temperature_tenths;
        return r;
    endfunction

    // advance the capture state by one sample and leave its records in step_recs
    function automatic void predict_sample(input t_in_item s);
        longint    mag;
        t_out_item r;
        step_recs.delete();
        mag = longint'(s.accel_x) * longint'(s.accel_x)
            + longint'(s.accel_y) * longint'(s.accel_y)
            + longint'(s.accel_z) * longint'(s.accel_z);
        if (sample_cnt != COUNT_MAX) sample_cnt++;
        if (!capturing_q && mag > longint'(thr_q) * longint'(thr_q)) begin
            capturing_q = 1'b1;
            step_recs.push_back(make_record(KIND_NOTICE, '0, '0, s));
        end
        if (!capturing_q) begin
            held[0]  = s;
            fill_idx = 1;
        end else if (fill_idx < CAPTURE_DEPTH) begin
            held[fill_idx] = s;
            fill_idx++;
        end else begin
            for (int i = 0; i < CAPTURE_DEPTH; i++) begin
                step_recs.push_back(make_record(KIND_SAMPLE, 4'(i), held[i], s));
            end
            sample_cnt  = '0;
            fill_idx    = 0;
            capturing_q = 1'b0;
        end
        if (sample_cnt > interval_q) begin
            sample_cnt = '0;
            step_recs.push_back(make_record(KIND_HEARTBEAT, '0, '0, s));
        end
        if (step_recs.size() > 0) begin
            r = step_recs.pop_back();
            r.last_record = 1'b1;
            step_recs.push_back(r);
        end
    endfunction

    function automatic t_in_item mk(input int ax, input int ay, input int az, input int gx,
                                    input int gy, input int gz, input int pres, input int temp);
        t_in_item s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.gyro_x  = 16'(gx);
        s.gyro_y  = 16'(gy);
        s.gyro_z  = 16'(gz);
        s.pressure_tenths    = 14'(pres);
        s.temperature_tenths = 12'(temp);
        return s;
    endfunction

    function automatic void add_sample(input t_in_item s, input bit typed, input int n,
                                       input logic [1:0] kind);
        t_stim_row row;
        row.kind       = ROW_SAMPLE;
        row.reg_id     = REG_THRESHOLD;
        row.value      = '0;
        row.item       = s;
        row.typed      = typed;
        row.typed_n    = n;
        row.typed_kind = kind;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [0:0] reg_id, input logic [15:0] value);
        t_stim_row row;
        row.kind       = ROW_CONFIG;
        row.reg_id     = reg_id;
        row.value      = value;
        row.item       = '0;
        row.typed      = 1'b0;
        row.typed_n    = 0;
        row.typed_kind = KIND_NOTICE;
        plan.push_back(row);
    endfunction

    function automatic t_stim_row rand_row();
        t_stim_row row;
        int        lim;
        int        half;
        int        v;
        int        mode;
        lim  = (thr_q > 16'd32767) ? 32767 : int'(thr_q);
        half = lim * 3 / 5 + 1;
        mode = $urandom_range(0, 9);
        row.kind       = ROW_SAMPLE;
        row.reg_id     = REG_THRESHOLD;
        row.value      = '0;
        row.typed      = 1'b0;
        row.typed_n    = 0;
        row.typed_kind = KIND_NOTICE;
        row.item = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        if (mode >= 3 && mode <= 8) begin
            // hover around the threshold so both sides of the compare get hit
            row.item.accel_x = 16'(int'($urandom_range(0, 2 * half)) - half);
            row.item.accel_y = 16'(int'($urandom_range(0, 2 * half)) - half);
            row.item.accel_z = 16'(int'($urandom_range(0, 2 * half)) - half);
        end else if (mode == 9) begin
            // single axis exactly at or one above the threshold
            v = lim + int'($urandom_range(0, 1));
            if (v > 32767) v = 32767;
            if ($urandom_range(0, 1) == 1) v = -v;
            row.item.accel_x = '0;
            row.item.accel_y = '0;
            row.item.accel_z = '0;
            case ($urandom_range(0, 2))
                0: row.item.accel_x = 16'(v);
                1: row.item.accel_y = 16'(v);
                default: row.item.accel_z = 16'(v);
            endcase
        end
        return row;
    endfunction

    task automatic send_sample(input t_stim_row row);
        int        gap;
        t_out_item r;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= row.item;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_sample(row.item);
        if (row.typed) begin
            if (row.typed_n > 0) begin
                r = make_record(row.typed_kind, '0, '0, row.item);
                r.last_record = 1'b1;
                pending_recs.push_back(r);
            end
        end else begin
            foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
        end
        samples_sent++;
    endtask

    // drain all outstanding records, then give the block time to finish silent work
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] reg_id, input logic [15:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd[15:0] !== value) begin
            report_mismatch($sformatf("register %0d reads %0d, wrote %0d", reg_id, rd[15:0],
                                      value));
        end
        if (reg_id == REG_THRESHOLD) thr_q = value;
        else interval_q = value;
        reg_writes++;
    endtask

    task automatic compare_record(input t_out_item got, input t_out_item want);
        if (got.record_kind !== want.record_kind)
            report_mismatch($sformatf("record_kind %0d, want %0d", got.record_kind,
                                      want.record_kind));
        if (got.record_number !== want.record_number)
            report_mismatch($sformatf("record_number %0d, want %0d", got.record_number,
                                      want.record_number));
        if (got.out_accel_x !== want.out_accel_x)
            report_mismatch($sformatf("out_accel_x %0d, want %0d", got.out_accel_x,
                                      want.out_accel_x));
        if (got.out_accel_y !== want.out_accel_y)
            report_mismatch($sformatf("out_accel_y %0d, want %0d", got.out_accel_y,
                                      want.out_accel_y));
        if (got.out_accel_z !== want.out_accel_z)
            report_mismatch($sformatf("out_accel_z %0d, want %0d", got.out_accel_z,
                                      want.out_accel_z));
        if (got.out_gyro_x !== want.out_gyro_x)
            report_mismatch($sformatf("out_gyro_x %0d, want %0d", got.out_gyro_x,
                                      want.out_gyro_x));
        if (got.out_gyro_y !== want.out_gyro_y)
            report_mismatch($sformatf("out_gyro_y %0d, want %0d", got.out_gyro_y,
                                      want.out_gyro_y));
        if (got.out_gyro_z !== want.out_gyro_z)
            report_mismatch($sformatf("out_gyro_z %0d, want %0d", got.out_gyro_z,
                                      want.out_gyro_z));
        if (got.out_pressure !== want.out_pressure)
            report_mismatch($sformatf("out_pressure %0d, want %0d", got.out_pressure,
                                      want.out_pressure));
        if (got.out_temperature !== want.out_temperature)
            report_mismatch($sformatf("out_temperature %0d, want %0d", got.out_temperature,
                                      want.out_temperature));
        if (got.last_record !== want.last_record)
            report_mismatch($sformatf("last_record %0d, want %0d", got.last_record,
                                      want.last_record));
    endtask

    // result side: random stall before each request, check on acceptance
    initial begin
        int        gap;
        t_out_item got;
        wait (rst_n === 1'b1);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got = out_data;
            case (got.record_kind)
                KIND_NOTICE: notice_seen++;
                KIND_SAMPLE: record_seen++;
                default: beat_seen++;
            endcase
            if (pending_recs.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d", got.record_kind));
            end else begin
                compare_record(got, pending_recs.pop_front());
            end
        end
    end

    initial begin
        logic [15:0] phase_thr[7];
        logic [15:0] phase_int[7];

        // reset values: idle sample, threshold tie, full-scale impact
        add_sample(mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, KIND_NOTICE);
        add_sample(mk(1500, 0, 0, 32767, -32768, 0, 16383, 2047), 1'b1, 0, KIND_NOTICE);
        add_sample(mk(-32768, -32768, -32768, -1, 0, 32767, 0, -2048), 1'b1, 1, KIND_NOTICE);
        for (int i = 0; i < CAPTURE_DEPTH - 2; i++) begin
            add_sample(mk(i * 5041 - 30000, 30000 - i * 4999, (i % 2) ? 32767 : -32768,
                          i * 2700 - 16000, -i * 2300, (i % 2) ? -32768 : 32767,
                          i * 1260, i * 300 - 2000), 1'b0, 0, KIND_NOTICE);
        end
        // buffer full: this one flushes every slot
        add_sample(mk(12, -34, 56, 7, 8, 9, 8191, -1), 1'b0, 0, KIND_NOTICE);
        // threshold zero, interval one, then interval zero
        add_cfg(REG_THRESHOLD, 16'd0);
        add_cfg(REG_INTERVAL, 16'd1);
        add_sample(mk(0, 0, 0, 100, 200, 300, 5000, 250), 1'b1, 0, KIND_NOTICE);
        add_sample(mk(0, 0, 0, -100, -200, -300, 5001, -250), 1'b1, 1, KIND_HEARTBEAT);
        add_sample(mk(0, 0, 1, 1, 2, 3, 42, 17), 1'b1, 1, KIND_NOTICE);
        add_sample(mk(0, 0, -1, 4, 5, 6, 43, -17), 1'b0, 0, KIND_NOTICE);
        add_cfg(REG_INTERVAL, 16'd0);
        add_sample(mk(777, -777, 0, 11, 22, 33, 9999, 1000), 1'b0, 0, KIND_NOTICE);
        add_sample(mk(-5, 5, -5, 44, 55, 66, 1, -1000), 1'b0, 0, KIND_NOTICE);

        phase_thr = '{16'd300, 16'd0, 16'hFFFF, 16'($urandom), 16'd1000,
                      16'($urandom_range(0, 4000)), THRESHOLD_RESET};
        phase_int = '{16'd20, 16'd2, 16'd1, 16'hFFFF, 16'd5,
                      16'($urandom_range(1, 65535)), INTERVAL_RESET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CONFIG) begin
                settle();
                write_register(plan[i].reg_id, plan[i].value);
            end else begin
                send_sample(plan[i]);
            end
        end

        for (int p = 0; p < 7; p++) begin
            settle();
            write_register(REG_THRESHOLD, phase_thr[p]);
            write_register(REG_INTERVAL, phase_int[p]);
            tx_quiet = (p == 1 || p == 4);
            rx_quiet = (p == 2 || p == 4);
            repeat (PHASE_SAMPLES) send_sample(rand_row());
        end

        settle();
        $display("Ran %0d samples across %0d register writes, thresholds 0 to 65535",
                 samples_sent, reg_writes);
        $display("Checked %0d trigger notices, %0d buffered records, %0d heartbeats",
                 notice_seen, record_seen, beat_seen);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
